// ----- sv/wbps_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, constants and helper functions for the wildcard byte pattern scanner.
// No dependencies; imported by the channel interfaces, the window cell and the top level.
package wbps_pkg;

  localparam int BYTE_W                 = 8;
  localparam int LEN_W                  = 5;
  localparam int CFG_DATA_W             = 64;
  localparam int CFG_IDX_W              = 2;
  localparam int MATCH_OFFSET_W         = 24;
  localparam int PATTERN_STORE_BYTES    = 24;
  localparam int DEF_MAX_PATTERN_BYTES  = 24;
  localparam int DEF_OFFSET_BITS        = 24;

  localparam logic [BYTE_W-1:0] WILDCARD          = 8'hFF;
  localparam logic [LEN_W-1:0]  PATTERN_LEN_RESET = 5'd24;

  typedef logic [BYTE_W-1:0] byte_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PAT_LOW  = 2'd0,
    CFG_PAT_MID  = 2'd1,
    CFG_PAT_HIGH = 2'd2,
    CFG_PAT_LEN  = 2'd3
  } cfg_reg_t;

  // A pattern byte equal to the wildcard value matches any data byte.
  function automatic logic byte_hit(input byte_t actual, input byte_t want);
    byte_hit = (want == WILDCARD) || (actual == want);
  endfunction

endpackage

// ----- sv/wbps_in_if.sv -----
`timescale 1ns / 1ps
// Input channel interface: one region byte and its end-of-region flag per transaction.
// Depends on wbps_pkg.
interface wbps_in_if import wbps_pkg::*; ();
  logic  valid;
  logic  ready;
  byte_t data_byte;
  logic  last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

// ----- sv/wbps_out_if.sv -----
`timescale 1ns / 1ps
// Result channel interface: found flag and match offset per transaction.
// Depends on wbps_pkg.
interface wbps_out_if import wbps_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic                      found;
  logic [MATCH_OFFSET_W-1:0] match_offset;

  modport source (output valid, output found, output match_offset, input ready);
  modport sink (input valid, input found, input match_offset, output ready);
endinterface

// ----- sv/wbps_cfg_if.sv -----
`timescale 1ns / 1ps
// Configuration write channel interface: register index and write data per transaction.
// Depends on wbps_pkg.
interface wbps_cfg_if import wbps_pkg::*; ();
  logic                  valid;
  logic                  ready;
  cfg_reg_t              index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ----- sv/wbps_cell.sv -----
`timescale 1ns / 1ps
// One window cell: holds a region byte, passes it to the next cell on every accepted
// transaction and compares it with its aligned pattern byte. Depends on wbps_pkg.
module wbps_cell import wbps_pkg::*; (
  input  logic  clk,
  input  logic  shift_en,
  input  byte_t d,
  input  byte_t want,
  output byte_t q,
  output logic  hit
);

  byte_t data_r;

  always_ff @(posedge clk) begin
    if (shift_en) begin
      data_r <= d;
    end
  end

  assign q   = data_r;
  assign hit = byte_hit(data_r, want);

endmodule

// ----- sv/wildcard_byte_pattern_scanner_unit.sv -----
`timescale 1ns / 1ps
// Wildcard byte pattern scanner top level. Depends on wbps_pkg, the channel interfaces and
// wbps_cell. Throughput is one byte per cycle; the newest byte and the window cells are
// compared against the aligned pattern in parallel in the accepting cycle.
// Results are registered in the output register; input stalls only while a result waits.
// Synchronous reset clears the byte count, the match flag, the output valid flag and the
// configuration registers to their defaults; the window bytes are not cleared.
module wildcard_byte_pattern_scanner_unit import wbps_pkg::*; #(
  parameter int MAX_PATTERN_BYTES = DEF_MAX_PATTERN_BYTES
) (
  input  logic       clk,
  input  logic       rst_n,
  wbps_in_if.sink    in_chan,
  wbps_out_if.source out_chan,
  wbps_cfg_if.sink   cfg_chan
);

  localparam int OFFSET_BITS = MATCH_OFFSET_W;
  localparam int CNT_W       = OFFSET_BITS + 1;

  logic [CFG_DATA_W-1:0] pat_low_r;
  logic [CFG_DATA_W-1:0] pat_mid_r;
  logic [CFG_DATA_W-1:0] pat_high_r;
  logic [LEN_W-1:0]      pat_len_r;

  logic [CNT_W-1:0] bytes_seen_r;
  logic [CNT_W-1:0] bytes_seen_nxt;
  logic             match_seen_r;
  logic             match_seen_nxt;

  logic                      out_valid_r;
  logic                      out_valid_nxt;
  logic                      found_r;
  logic                      found_nxt;
  logic [MATCH_OFFSET_W-1:0] offset_r;
  logic [MATCH_OFFSET_W-1:0] offset_nxt;

  logic [3*CFG_DATA_W-1:0] pat_all;
  byte_t                   pat_byte [PATTERN_STORE_BYTES];
  byte_t                   aligned [MAX_PATTERN_BYTES];
  byte_t                   chain [MAX_PATTERN_BYTES];
  logic [MAX_PATTERN_BYTES-1:0] hits;

  logic [LEN_W-1:0] len_use;
  logic [CNT_W-1:0] len_m1;
  logic [CNT_W-1:0] start;
  logic             enough;
  logic             start_fits;
  logic             hit;
  logic             in_fire;

  assign in_chan.ready = !out_valid_r || out_chan.ready;
  assign in_fire       = in_chan.valid && in_chan.ready;
  assign cfg_chan.ready = 1'b1;

  assign out_chan.valid        = out_valid_r;
  assign out_chan.found        = found_r;
  assign out_chan.match_offset = offset_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_low_r  <= '0;
      pat_mid_r  <= '0;
      pat_high_r <= '0;
      pat_len_r  <= PATTERN_LEN_RESET;
    end else if (cfg_chan.valid) begin
      unique case (cfg_chan.index)
        CFG_PAT_LOW:  pat_low_r  <= cfg_chan.data;
        CFG_PAT_MID:  pat_mid_r  <= cfg_chan.data;
        CFG_PAT_HIGH: pat_high_r <= cfg_chan.data;
        CFG_PAT_LEN:  pat_len_r  <= cfg_chan.data[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  assign pat_all = {pat_high_r, pat_mid_r, pat_low_r};

  always_comb begin
    for (int j = 0; j < PATTERN_STORE_BYTES; j++) begin
      pat_byte[j] = pat_all[BYTE_W*j +: BYTE_W];
    end
  end

  always_comb begin
    len_use = pat_len_r;
    if (pat_len_r == '0) begin
      len_use = LEN_W'(1);
    end else if (pat_len_r > LEN_W'(MAX_PATTERN_BYTES)) begin
      len_use = LEN_W'(MAX_PATTERN_BYTES);
    end
  end

  // Position 0 is the incoming byte and position b is the byte seen b transactions ago;
  // it meets pattern byte len - 1 - b, and positions past the pattern are don't-care.
  always_comb begin
    for (int b = 0; b < MAX_PATTERN_BYTES; b++) begin
      aligned[b] = WILDCARD;
      for (int j = 0; j < MAX_PATTERN_BYTES; j++) begin
        if (int'(len_use) == j + b + 1) begin
          aligned[b] = pat_byte[j];
        end
      end
    end
  end

  assign chain[0] = in_chan.data_byte;
  assign hits[0]  = byte_hit(in_chan.data_byte, aligned[0]);

  for (genvar b = 1; b < MAX_PATTERN_BYTES; b++) begin : g_cell
    wbps_cell u_cell (
      .clk      (clk),
      .shift_en (in_fire),
      .d        (chain[b-1]),
      .want     (aligned[b]),
      .q        (chain[b]),
      .hit      (hits[b])
    );
  end

  assign len_m1     = CNT_W'(len_use - LEN_W'(1));
  assign enough     = bytes_seen_r >= len_m1;
  assign start      = bytes_seen_r - len_m1;
  assign start_fits = !start[CNT_W-1];
  assign hit        = (&hits) && enough && start_fits && !match_seen_r;

  always_comb begin
    bytes_seen_nxt = bytes_seen_r;
    match_seen_nxt = match_seen_r;
    out_valid_nxt  = out_valid_r && !out_chan.ready;
    found_nxt      = found_r;
    offset_nxt     = offset_r;
    if (in_fire) begin
      if (hit) begin
        out_valid_nxt = 1'b1;
        found_nxt     = 1'b1;
        offset_nxt    = MATCH_OFFSET_W'(start[OFFSET_BITS-1:0]);
      end else if (in_chan.last_byte && !match_seen_r) begin
        out_valid_nxt = 1'b1;
        found_nxt     = 1'b0;
        offset_nxt    = '0;
      end
      if (in_chan.last_byte) begin
        bytes_seen_nxt = '0;
        match_seen_nxt = 1'b0;
      end else begin
        match_seen_nxt = match_seen_r || hit;
        if (bytes_seen_r != '1) begin
          bytes_seen_nxt = bytes_seen_r + CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bytes_seen_r <= '0;
      match_seen_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      bytes_seen_r <= bytes_seen_nxt;
      match_seen_r <= match_seen_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    found_r  <= found_nxt;
    offset_r <= offset_nxt;
  end

  a_region_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_chan.last_byte |=> bytes_seen_r == '0 && !match_seen_r)
    else $error("Region state not cleared after the last byte.");

  a_match_flag_with_result: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(match_seen_r) |-> out_valid_r && found_r)
    else $error("Match flag set without a found result.");

  a_count_advances: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && !in_chan.last_byte && bytes_seen_r != '1
      |=> bytes_seen_r == $past(bytes_seen_r) + CNT_W'(1))
    else $error("Byte count did not advance on an accepted transaction.");

  a_no_result_after_match: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && match_seen_r && (out_valid_r == 1'b0 || out_chan.ready) |=> !out_valid_r)
    else $error("Result produced after the first match of a region.");

endmodule

// ----- bench/wbps_scan_checker.sv -----
`timescale 1ns / 1ps
// Checker for the wildcard byte pattern scanner: watches the input, result and configuration
// channels, predicts each scan result and compares it with the block. Depends on wbps_pkg
// and the wbps channel interfaces.
module wbps_scan_checker import wbps_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  wbps_in_if          in_chan,
  wbps_out_if         out_chan,
  wbps_cfg_if         cfg_chan,
  output int unsigned mismatch_count,
  output int unsigned reports_pending
);

  localparam int unsigned WINDOW_DEPTH = DEF_MAX_PATTERN_BYTES - 1;
  localparam int unsigned OFFSET_LIMIT = (1 << DEF_OFFSET_BITS) - 1;
  localparam int unsigned COUNT_LIMIT  = (1 << (DEF_OFFSET_BITS + 1)) - 1;

  typedef struct packed {
    logic                      found;
    logic [MATCH_OFFSET_W-1:0] offset;
  } scan_report_t;

  scan_report_t          expected_reports[$];
  logic [CFG_DATA_W-1:0] pat_words[3];
  logic [LEN_W-1:0]      pat_len_raw;
  byte_t                 window[WINDOW_DEPTH];
  int unsigned           bytes_seen;
  bit                    match_seen;

  task automatic report_mismatch(input string what);
    $display("%0t ns: mismatch: %s", $time, what);
    mismatch_count++;
  endtask

  task automatic clear_region();
    foreach (window[i]) window[i] = '0;
    bytes_seen = 0;
    match_seen = 1'b0;
  endtask

  task automatic scan_byte(input byte_t cur, input logic last);
    int unsigned                used;
    int unsigned                start;
    int unsigned                back;
    logic                       hit;
    byte_t                      actual;
    byte_t                      want;
    logic [3*CFG_DATA_W-1:0]    pat;
    scan_report_t               rpt;
    used = pat_len_raw;
    if (used == 0) used = 1;
    if (used > DEF_MAX_PATTERN_BYTES) used = DEF_MAX_PATTERN_BYTES;
    pat = {pat_words[2], pat_words[1], pat_words[0]};
    if (!match_seen && bytes_seen + 1 >= used) begin
      start = bytes_seen + 1 - used;
      hit = 1'b1;
      for (int unsigned j = 0; j < used; j++) begin
        back = used - 1 - j;
        actual = (back == 0) ? cur : window[back-1];
        want = pat[j*BYTE_W +: BYTE_W];
        if (want != WILDCARD && actual != want) hit = 1'b0;
      end
      if (hit && start <= OFFSET_LIMIT) begin
        match_seen = 1'b1;
        rpt.found = 1'b1;
        rpt.offset = start[MATCH_OFFSET_W-1:0];
        expected_reports.push_back(rpt);
      end
    end
    for (int k = WINDOW_DEPTH - 1; k > 0; k--) window[k] = window[k-1];
    window[0] = cur;
    if (bytes_seen < COUNT_LIMIT) bytes_seen++;
    if (last) begin
      if (!match_seen) begin
        rpt.found = 1'b0;
        rpt.offset = '0;
        expected_reports.push_back(rpt);
      end
      clear_region();
    end
  endtask

  always @(posedge clk) begin
    scan_report_t exp_rpt;
    if (!rst_n) begin
      pat_words[0] = '0;
      pat_words[1] = '0;
      pat_words[2] = '0;
      pat_len_raw = PATTERN_LEN_RESET;
      clear_region();
      expected_reports.delete();
    end else begin
      if (cfg_chan.valid && cfg_chan.ready) begin
        case (cfg_chan.index)
          CFG_PAT_LOW:  pat_words[0] = cfg_chan.data;
          CFG_PAT_MID:  pat_words[1] = cfg_chan.data;
          CFG_PAT_HIGH: pat_words[2] = cfg_chan.data;
          CFG_PAT_LEN:  pat_len_raw = cfg_chan.data[LEN_W-1:0];
          default: report_mismatch("configuration write with unknown index");
        endcase
      end
      if (in_chan.valid && in_chan.ready) scan_byte(in_chan.data_byte, in_chan.last_byte);
      if (out_chan.valid && out_chan.ready) begin
        if (expected_reports.size() == 0) begin
          report_mismatch($sformatf("result found=%0b offset=%0d with nothing expected",
                                    out_chan.found, out_chan.match_offset));
        end else begin
          exp_rpt = expected_reports.pop_front();
          if (out_chan.found !== exp_rpt.found)
            report_mismatch($sformatf("found is %b, expected %b", out_chan.found,
                                      exp_rpt.found));
          if (out_chan.match_offset !== exp_rpt.offset)
            report_mismatch($sformatf("match_offset is %0d, expected %0d",
                                      out_chan.match_offset, exp_rpt.offset));
        end
      end
    end
    reports_pending = expected_reports.size();
  end

endmodule

// ----- bench/tb_wildcard_byte_pattern_scanner_unit.sv -----
`timescale 1ns / 1ps
// Testbench top for the wildcard byte pattern scanner: clock, reset, stimulus and verdict.
// Depends on wbps_pkg, the wbps channel interfaces, the block and wbps_scan_checker.
module tb_wildcard_byte_pattern_scanner_unit;
  import wbps_pkg::*;

  logic clk;
  logic rst_n;

  wbps_in_if  in_chan();
  wbps_out_if out_chan();
  wbps_cfg_if cfg_chan();

  int unsigned mismatch_count;
  int unsigned reports_pending;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned bytes_sent;
  int unsigned pat_used;
  byte_t       pat_bytes[DEF_MAX_PATTERN_BYTES];

  wildcard_byte_pattern_scanner_unit i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_chan (cfg_chan)
  );

  wbps_scan_checker i_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_chan         (in_chan),
    .out_chan        (out_chan),
    .cfg_chan        (cfg_chan),
    .mismatch_count  (mismatch_count),
    .reports_pending (reports_pending)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(negedge clk) begin
    out_chan.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  initial begin
    #2000000;
    $display("Simulation FAILED");
    $finish;
  end

  task automatic push_byte(input byte_t d, input logic l);
    while ($urandom_range(99) < send_idle_pct) begin
      in_chan.valid <= 1'b0;
      @(negedge clk);
    end
    in_chan.valid <= 1'b1;
    in_chan.data_byte <= d;
    in_chan.last_byte <= l;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_region(input byte_t bytes[$]);
    foreach (bytes[i]) push_byte(bytes[i], i == bytes.size() - 1);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
    cfg_chan.valid <= 1'b1;
    cfg_chan.index <= idx;
    cfg_chan.data <= val;
    @(posedge clk);
    while (!cfg_chan.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic load_pattern(input logic [LEN_W-1:0] raw_len);
    logic [3*CFG_DATA_W-1:0] pat;
    logic [CFG_DATA_W-1:0]   len_word;
    in_chan.valid <= 1'b0;
    while (reports_pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    foreach (pat_bytes[j]) pat[j*BYTE_W +: BYTE_W] = pat_bytes[j];
    len_word = {$urandom, $urandom};
    len_word[LEN_W-1:0] = raw_len;
    write_reg(CFG_PAT_LOW, pat[CFG_DATA_W-1:0]);
    write_reg(CFG_PAT_MID, pat[2*CFG_DATA_W-1:CFG_DATA_W]);
    write_reg(CFG_PAT_HIGH, pat[3*CFG_DATA_W-1:2*CFG_DATA_W]);
    write_reg(CFG_PAT_LEN, len_word);
    cfg_chan.valid <= 1'b0;
    pat_used = (raw_len == 0) ? 1 : (raw_len > DEF_MAX_PATTERN_BYTES) ?
               DEF_MAX_PATTERN_BYTES : raw_len;
  endtask

  task automatic random_pattern(input int unsigned mode);
    logic [LEN_W-1:0] raw_len;
    foreach (pat_bytes[j])
      pat_bytes[j] = ($urandom_range(3) == 0) ? WILDCARD : byte_t'($urandom_range(254));
    case (mode)
      0: raw_len = 5'd24;
      1: raw_len = 5'd1;
      2: raw_len = $urandom_range(1) ? 5'd0 : 5'($urandom_range(25, 31));
      default: raw_len = 5'($urandom_range(1, 24));
    endcase
    load_pattern(raw_len);
  endtask

  task automatic random_region();
    byte_t       bytes[$];
    int unsigned rlen;
    int unsigned pos;
    int unsigned victim;
    rlen = ($urandom_range(9) == 0) ? $urandom_range(40, 90) : $urandom_range(1, 40);
    for (int unsigned k = 0; k < rlen; k++) bytes.push_back(byte_t'($urandom_range(255)));
    if ($urandom_range(9) < 7 && rlen >= pat_used) begin
      repeat ($urandom_range(1, 2)) begin
        pos = ($urandom_range(3) == 0) ? rlen - pat_used : $urandom_range(0, rlen - pat_used);
        for (int unsigned j = 0; j < pat_used; j++)
          if (pat_bytes[j] != WILDCARD) bytes[pos+j] = pat_bytes[j];
      end
      if ($urandom_range(3) == 0) begin
        victim = $urandom_range(0, pat_used - 1);
        if (pat_bytes[victim] != WILDCARD)
          bytes[pos+victim] = pat_bytes[victim] ^ (8'h01 << $urandom_range(7));
      end
    end
    send_region(bytes);
  endtask

  initial begin
    rst_n = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    bytes_sent = 0;
    pat_used = DEF_MAX_PATTERN_BYTES;
    in_chan.valid = 1'b0;
    in_chan.data_byte = '0;
    in_chan.last_byte = 1'b0;
    out_chan.ready = 1'b0;
    cfg_chan.valid = 1'b0;
    cfg_chan.index = CFG_PAT_LOW;
    cfg_chan.data = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (pat_bytes[j]) pat_bytes[j] = 8'h00;
    pat_bytes[0] = 8'hA5;
    pat_bytes[1] = WILDCARD;
    load_pattern(5'd0);
    send_region('{8'h00, 8'hA5, 8'hA5});
    send_region('{8'h7F});
    send_region('{8'hA5});

    foreach (pat_bytes[j]) pat_bytes[j] = WILDCARD;
    load_pattern(5'd31);
    send_region('{8'hFF, 8'h00, 8'h80});

    foreach (pat_bytes[j]) pat_bytes[j] = 8'h00;
    pat_bytes[1] = WILDCARD;
    pat_bytes[2] = 8'hFE;
    load_pattern(5'd3);
    send_region('{8'hFF, 8'h00, 8'h12, 8'hFE});

    for (int unsigned phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 77; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 77; end
        default: begin send_idle_pct = 15; recv_stall_pct = 15; end
      endcase
      for (int unsigned sub = 0; sub < 4; sub++) begin
        random_pattern((phase * 4 + sub) % 5);
        while (bytes_sent < 12 + (phase * 4 + sub + 1) * 34) random_region();
      end
    end

    in_chan.valid <= 1'b0;
    while (reports_pending != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
